/* sv/near_duplicate_frame_dropper_defines.svh */
// ----------------------------------------------------------------------------
// Near-duplicate frame dropper assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NEAR_DUPLICATE_FRAME_DROPPER_DEFINES_SVH
`define NEAR_DUPLICATE_FRAME_DROPPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NDFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NDFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ndfd_pkg.sv */
// ----------------------------------------------------------------------------
// ndfd_pkg
// Types and constants of the near-duplicate frame dropper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndfd_pkg;

    localparam int PIX        = 8;
    localparam int ROW_W      = 11;
    localparam int SUM_W      = 14;
    localparam int CNT_W      = 24;
    localparam int LIM_W      = 21;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    localparam logic [SUM_W-1:0] SUM_MAX = 14'h3FFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 24'hFFFFFF;
    localparam logic [2:0]       SETTLE_CYCLES = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THR    = 4'd0,
        REG_HIGH_THR   = 4'd1,
        REG_CHANGE_FR  = 4'd2,
        REG_DROP_LIMIT = 4'd3,
        REG_WIDTH      = 4'd4,
        REG_HEIGHT     = 4'd5,
        REG_CHROMA_H   = 4'd6,
        REG_CHROMA_V   = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [63:0] cur_pixels;
        logic [63:0] ref_pixels;
        logic [1:0]  plane_index;
        logic        block_row_last;
        logic        plane_last;
        logic        frame_last;
    } in_item_t;

    typedef struct packed {
        logic               drop_frame;
        logic signed [15:0] run_count;
    } out_item_t;

    typedef struct packed {
        logic [13:0]        low_threshold;
        logic [13:0]        high_threshold;
        logic [16:0]        change_fraction;
        logic signed [15:0] drop_limit;
        logic [13:0]        frame_width;
        logic [13:0]        frame_height;
        logic [1:0]         chroma_h_shift;
        logic [1:0]         chroma_v_shift;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic blk_end;
        logic plane_last;
        logic frame_last;
        logic chroma;
    } row_flags_t;

    typedef struct packed {
        logic [LIM_W-1:0] luma;
        logic [LIM_W-1:0] chroma;
    } limits_t;

    typedef struct packed {
        logic push;
        logic differs;
    } verdict_t;

endpackage

`default_nettype wire

/* sv/ndfd_limit.sv */
// ----------------------------------------------------------------------------
// ndfd_limit
// Three-stage pipeline computing the changed-block limits of luma and chroma.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndfd_limit (
    input  wire logic            aclk,
    input  wire ndfd_pkg::cfg_t  cfg,
    output ndfd_pkg::limits_t    limits
);

    logic [9:0]  luma_w_reg, luma_h_reg, chroma_w_reg, chroma_h_reg;
    logic [19:0] luma_area_reg, chroma_area_reg;
    logic [16:0] frac_reg;
    ndfd_pkg::limits_t limits_reg;

    logic [2:0]  mask_h, mask_v;
    logic [14:0] cw_sum, ch_sum, cw_shift, ch_shift;
    logic [36:0] luma_prod, chroma_prod;

    always_comb begin
        mask_h   = ~(3'b111 << cfg.chroma_h_shift);
        mask_v   = ~(3'b111 << cfg.chroma_v_shift);
        cw_sum   = {1'b0, cfg.frame_width} + {12'd0, mask_h};
        ch_sum   = {1'b0, cfg.frame_height} + {12'd0, mask_v};
        cw_shift = cw_sum >> cfg.chroma_h_shift;
        ch_shift = ch_sum >> cfg.chroma_v_shift;
        luma_prod   = {17'd0, luma_area_reg} * {20'd0, frac_reg};
        chroma_prod = {17'd0, chroma_area_reg} * {20'd0, frac_reg};
    end

    always_ff @(posedge aclk) begin
        luma_w_reg      <= cfg.frame_width[13:4];
        luma_h_reg      <= cfg.frame_height[13:4];
        chroma_w_reg    <= cw_shift[13:4];
        chroma_h_reg    <= ch_shift[13:4];
        frac_reg        <= cfg.change_fraction;
        luma_area_reg   <= {10'd0, luma_w_reg} * {10'd0, luma_h_reg};
        chroma_area_reg <= {10'd0, chroma_w_reg} * {10'd0, chroma_h_reg};
        limits_reg.luma   <= luma_prod[36:16];
        limits_reg.chroma <= chroma_prod[36:16];
    end

    assign limits = limits_reg;

endmodule

`default_nettype wire

/* sv/ndfd_front.sv */
// ----------------------------------------------------------------------------
// ndfd_front
// Row SAD pipeline, block accumulation and block judgement; emits one
// verdict per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndfd_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire ndfd_pkg::in_item_t  in_item,
    input  wire ndfd_pkg::cfg_t      cfg,
    input  wire ndfd_pkg::limits_t   limits,
    output ndfd_pkg::verdict_t       verdict,
    output logic [1:0]               pending
);

    logic [7:0] diff_reg [ndfd_pkg::PIX];
    ndfd_pkg::row_flags_t a_flags_reg, b_flags_reg, c_flags_reg;
    logic [ndfd_pkg::ROW_W-1:0] row_sad_reg, row_sad_next;
    logic [ndfd_pkg::SUM_W-1:0] block_sum_reg, block_sum_next, blk_reg, blk_sat;
    logic [ndfd_pkg::SUM_W:0]   acc;
    logic [ndfd_pkg::CNT_W-1:0] changed_reg, changed_next, cnt_inc;
    logic [ndfd_pkg::LIM_W-1:0] limit;
    logic differs_reg, differs_next;
    logic [7:0] diff_next [ndfd_pkg::PIX];
    ndfd_pkg::row_flags_t in_flags;

    always_comb begin
        for (int i = 0; i < ndfd_pkg::PIX; i++) begin
            diff_next[i] = (in_item.cur_pixels[8*i +: 8] > in_item.ref_pixels[8*i +: 8])
                ? in_item.cur_pixels[8*i +: 8] - in_item.ref_pixels[8*i +: 8]
                : in_item.ref_pixels[8*i +: 8] - in_item.cur_pixels[8*i +: 8];
        end
        in_flags.valid      = in_accept;
        in_flags.blk_end    = in_item.block_row_last;
        in_flags.plane_last = in_item.plane_last;
        in_flags.frame_last = in_item.frame_last;
        in_flags.chroma     = (in_item.plane_index == 2'd1) || (in_item.plane_index == 2'd2);
    end

    always_comb begin
        row_sad_next = '0;
        for (int i = 0; i < ndfd_pkg::PIX; i++) begin
            row_sad_next = row_sad_next + {3'd0, diff_reg[i]};
        end
    end

    always_comb begin
        acc     = {1'b0, block_sum_reg} + {4'd0, row_sad_reg};
        blk_sat = acc[ndfd_pkg::SUM_W] ? ndfd_pkg::SUM_MAX : acc[ndfd_pkg::SUM_W-1:0];
        block_sum_next = block_sum_reg;
        if (b_flags_reg.valid) begin
            block_sum_next = (b_flags_reg.blk_end || b_flags_reg.frame_last) ? '0 : blk_sat;
        end
    end

    always_comb begin
        limit   = c_flags_reg.chroma ? limits.chroma : limits.luma;
        cnt_inc = (changed_reg == ndfd_pkg::CNT_MAX) ? changed_reg : changed_reg + 1'b1;
        changed_next = changed_reg;
        differs_next = differs_reg;
        verdict.push    = 1'b0;
        verdict.differs = 1'b0;
        if (c_flags_reg.valid) begin
            if (c_flags_reg.blk_end) begin
                if (blk_reg > cfg.high_threshold) begin
                    differs_next = 1'b1;
                end else if (blk_reg > cfg.low_threshold) begin
                    changed_next = cnt_inc;
                    if (cnt_inc > {3'd0, limit}) begin
                        differs_next = 1'b1;
                    end
                end
            end
            if (c_flags_reg.plane_last || c_flags_reg.frame_last) begin
                changed_next = '0;
            end
            if (c_flags_reg.frame_last) begin
                verdict.push    = 1'b1;
                verdict.differs = differs_next;
                differs_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_flags_reg   <= '0;
            b_flags_reg   <= '0;
            c_flags_reg   <= '0;
            block_sum_reg <= '0;
            changed_reg   <= '0;
            differs_reg   <= 1'b0;
        end else begin
            a_flags_reg   <= in_flags;
            b_flags_reg   <= a_flags_reg;
            c_flags_reg   <= b_flags_reg;
            block_sum_reg <= block_sum_next;
            changed_reg   <= changed_next;
            differs_reg   <= differs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            diff_reg <= diff_next;
        end
        row_sad_reg <= row_sad_next;
        blk_reg     <= blk_sat;
    end

    assign pending = {1'b0, a_flags_reg.valid && a_flags_reg.frame_last}
                   + {1'b0, b_flags_reg.valid && b_flags_reg.frame_last}
                   + {1'b0, c_flags_reg.valid && c_flags_reg.frame_last};

endmodule

`default_nettype wire

/* sv/ndfd_queue.sv */
// ----------------------------------------------------------------------------
// ndfd_queue
// Small FIFO of frame verdicts between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndfd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire ndfd_pkg::verdict_t         verdict,
    input  wire logic                       pop,
    output logic                            head_differs,
    output logic [$clog2(DEPTH+1)-1:0]      count,
    output logic                            empty,
    output logic                            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [DEPTH-1:0] mem_reg;
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (verdict.push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (verdict.push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !verdict.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (verdict.push) begin
            mem_reg[wr_ptr_reg] <= verdict.differs;
        end
    end

    assign head_differs = mem_reg[rd_ptr_reg];
    assign count        = count_reg;
    assign empty        = (count_reg == '0);
    assign full         = (count_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

/* sv/ndfd_back.sv */
// ----------------------------------------------------------------------------
// ndfd_back
// Drop decision, run counter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndfd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire logic               q_differs,
    input  wire logic signed [15:0] drop_limit,
    input  wire logic               m_ready,
    output logic                    pop,
    output logic                    m_valid,
    output ndfd_pkg::out_item_t     m_item
);

    logic signed [15:0] run_reg, run_next, inc, dec;
    logic signed [16:0] run_m1, limit_ext;
    logic have_ref_reg, have_ref_next;
    logic m_valid_reg, m_valid_next;
    ndfd_pkg::out_item_t item_reg;
    logic drop, keep_max, keep_gap;

    always_comb begin
        pop       = !q_empty && (!m_valid_reg || m_ready);
        run_m1    = {run_reg[15], run_reg} - 17'sd1;
        limit_ext = {drop_limit[15], drop_limit};
        keep_max  = (drop_limit > 16'sd0) && (run_reg >= drop_limit);
        keep_gap  = (drop_limit < 16'sd0) && (run_m1 > limit_ext);
        drop      = have_ref_reg && !q_differs && !keep_max && !keep_gap;
        inc = (run_reg == 16'sh7FFF) ? run_reg : run_reg + 16'sd1;
        dec = (run_reg == -16'sh8000) ? run_reg : run_reg - 16'sd1;
        if (inc < 16'sd1) begin
            inc = 16'sd1;
        end
        if (dec > -16'sd1) begin
            dec = -16'sd1;
        end
        run_next      = run_reg;
        have_ref_next = have_ref_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (pop) begin
            run_next      = drop ? inc : dec;
            have_ref_next = have_ref_reg || !drop;
            m_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= '0;
            have_ref_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            run_reg      <= run_next;
            have_ref_reg <= have_ref_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg.drop_frame <= drop;
            item_reg.run_count  <= run_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = item_reg;

endmodule

`default_nettype wire

/* sv/near_duplicate_frame_dropper.sv */
// ----------------------------------------------------------------------------
// near_duplicate_frame_dropper
// Top level: configuration registers, limit pipeline, front, verdict queue
// and back.
// ----------------------------------------------------------------------------
// Each input item is one 8-pixel row of a current 8x8 block and the same row
// of the reference. Blocks, planes and frames are delimited by the row flags.
// One result item is produced for each row that carries frame_last; other
// rows produce none. Rows are taken one per cycle while s_ready is high.
// From the frame_last item to m_valid the verdict passes three pipeline
// stages of difference, row sum and block accumulation, the judgement that
// pushes the verdict queue, and the output register.
// The verdict queue holds QUEUE_DEPTH frames; s_ready falls when verdicts in
// flight plus those queued would fill it, so a stalled receiver only stops
// the input after several frames.
// A configuration write is taken at once and holds s_ready low while the
// plane limits are recomputed by a three-stage multiplier pipeline. Reset
// restores the register defaults, clears all frame state and likewise holds
// s_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "near_duplicate_frame_dropper_defines.svh"

module near_duplicate_frame_dropper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire ndfd_pkg::in_item_t                  s_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output ndfd_pkg::out_item_t                      m_item,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ndfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ndfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    ndfd_pkg::cfg_t     cfg_reg;
    ndfd_pkg::limits_t  limits;
    ndfd_pkg::verdict_t verdict;
    logic [2:0]      settle_reg;
    logic [1:0]      pending;
    logic [QC_W-1:0] q_count;
    logic [QC_W+1:0] q_used;
    logic q_empty, q_full, q_differs, q_pop;
    logic cfg_write, in_accept;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign q_used    = {2'b00, q_count} + {QC_W'(0), pending};
    assign s_ready   = (settle_reg == 3'd0) && (q_used < (QC_W+2)'(QUEUE_DEPTH));
    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_threshold   <= 14'd320;
            cfg_reg.high_threshold  <= 14'd768;
            cfg_reg.change_fraction <= 17'd21627;
            cfg_reg.drop_limit      <= 16'sd0;
            cfg_reg.frame_width     <= 14'd1920;
            cfg_reg.frame_height    <= 14'd1080;
            cfg_reg.chroma_h_shift  <= 2'd1;
            cfg_reg.chroma_v_shift  <= 2'd1;
            settle_reg              <= ndfd_pkg::SETTLE_CYCLES;
        end else begin
            if (cfg_write) begin
                settle_reg <= ndfd_pkg::SETTLE_CYCLES;
                case (ndfd_pkg::cfg_reg_t'(cfg_index))
                    ndfd_pkg::REG_LOW_THR:    cfg_reg.low_threshold   <= cfg_data[13:0];
                    ndfd_pkg::REG_HIGH_THR:   cfg_reg.high_threshold  <= cfg_data[13:0];
                    ndfd_pkg::REG_CHANGE_FR:  cfg_reg.change_fraction <= cfg_data;
                    ndfd_pkg::REG_DROP_LIMIT: cfg_reg.drop_limit      <= cfg_data[15:0];
                    ndfd_pkg::REG_WIDTH:      cfg_reg.frame_width     <= cfg_data[13:0];
                    ndfd_pkg::REG_HEIGHT:     cfg_reg.frame_height    <= cfg_data[13:0];
                    ndfd_pkg::REG_CHROMA_H:   cfg_reg.chroma_h_shift  <= cfg_data[1:0];
                    ndfd_pkg::REG_CHROMA_V:   cfg_reg.chroma_v_shift  <= cfg_data[1:0];
                    default: begin
                    end
                endcase
            end else if (settle_reg != 3'd0) begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    ndfd_limit u_limit (
        .aclk   (aclk),
        .cfg    (cfg_reg),
        .limits (limits)
    );

    ndfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (s_item),
        .cfg       (cfg_reg),
        .limits    (limits),
        .verdict   (verdict),
        .pending   (pending)
    );

    ndfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .verdict      (verdict),
        .pop          (q_pop),
        .head_differs (q_differs),
        .count        (q_count),
        .empty        (q_empty),
        .full         (q_full)
    );

    ndfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_differs  (q_differs),
        .drop_limit (cfg_reg.drop_limit),
        .m_ready    (m_ready),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_item     (m_item)
    );

    `NDFD_ASSERT_NXT(a_cfg_holds_input, cfg_write, !s_ready, "item taken during limit update")
    `NDFD_ASSERT_IMP(a_no_overflow, verdict.push, !q_full || q_pop, "verdict queue overflow")
    `NDFD_ASSERT_IMP(a_no_underflow, q_pop, !q_empty, "verdict queue underflow")
    `NDFD_ASSERT_IMP(a_run_sign, m_valid,
        (m_item.drop_frame && !m_item.run_count[15] && (m_item.run_count != 16'sd0)) ||
        (!m_item.drop_frame && m_item.run_count[15]), "run counter sign mismatch")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the near-duplicate frame dropper. Rows of 8x8
// blocks are streamed through the valid/ready input while the registers are
// reprogrammed between phases. A scoreboard predicts every drop/keep decision
// and run count from the accepted rows, and each result item is compared with
// the oldest prediction. Both sides idle at random, the receiver once stalls
// long enough to back up the input, and runs of duplicate single-row frames
// build long runs of drops and of keeps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int    RANDOM_ROWS   = 900;
    localparam int    RANDOM_PHASES = 6;
    localparam int    DRAIN_CYCLES  = 8;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    SAT_FRAMES    = 30;
    localparam longint TIMEOUT_NS   = 64'd10_000_000;

    class decision_board;
        logic [13:0] low_thr, high_thr, width, height;
        logic [16:0] fraction;
        int          drop_lim;
        logic [1:0]  h_shift, v_shift;
        int          run_ctr;
        bit          have_ref, differs;
        int unsigned blk_sum, changed;
        ndfd_pkg::out_item_t decisions_q[$];
        int          decided;
        int          mismatches;

        function new();
            low_thr    = 14'd320;
            high_thr   = 14'd768;
            fraction   = 17'd21627;
            drop_lim   = 0;
            width      = 14'd1920;
            height     = 14'd1080;
            h_shift    = 2'd1;
            v_shift    = 2'd1;
            run_ctr    = 0;
            have_ref   = 1'b0;
            differs    = 1'b0;
            blk_sum    = 0;
            changed    = 0;
            decided    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(ndfd_pkg::cfg_reg_t idx, logic [ndfd_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                ndfd_pkg::REG_LOW_THR:    low_thr  = v[13:0];
                ndfd_pkg::REG_HIGH_THR:   high_thr = v[13:0];
                ndfd_pkg::REG_CHANGE_FR:  fraction = v[16:0];
                ndfd_pkg::REG_DROP_LIMIT: drop_lim = int'($signed(v[15:0]));
                ndfd_pkg::REG_WIDTH:      width    = v[13:0];
                ndfd_pkg::REG_HEIGHT:     height   = v[13:0];
                ndfd_pkg::REG_CHROMA_H:   h_shift  = v[1:0];
                ndfd_pkg::REG_CHROMA_V:   v_shift  = v[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned plane_limit(logic [1:0] plane);
            int unsigned     hs, vs, w16, h16;
            longint unsigned prod;
            hs = 0;
            vs = 0;
            if (plane == 2'd1 || plane == 2'd2) begin
                hs = 32'(h_shift);
                vs = 32'(v_shift);
            end
            w16  = ((32'(width) + (32'd1 << hs) - 32'd1) >> hs) / 32'd16;
            h16  = ((32'(height) + (32'd1 << vs) - 32'd1) >> vs) / 32'd16;
            prod = (64'(w16) * 64'(h16) * 64'(fraction)) >> 16;
            return (prod > 64'(ndfd_pkg::CNT_MAX)) ? 32'(ndfd_pkg::CNT_MAX) : 32'(prod);
        endfunction

        function void note_row(ndfd_pkg::in_item_t it);
            int unsigned lim, sad, a, b;
            int          n;
            bit          drop;
            ndfd_pkg::out_item_t res;
            lim = plane_limit(it.plane_index);
            sad = 0;
            for (int i = 0; i < 8; i++) begin
                a = 32'(it.cur_pixels[8*i +: 8]);
                b = 32'(it.ref_pixels[8*i +: 8]);
                sad += (a > b) ? a - b : b - a;
            end
            blk_sum = (blk_sum + sad > 32'(ndfd_pkg::SUM_MAX)) ? 32'(ndfd_pkg::SUM_MAX)
                                                              : blk_sum + sad;
            if (it.block_row_last) begin
                if (blk_sum > 32'(high_thr)) begin
                    differs = 1'b1;
                end else if (blk_sum > 32'(low_thr)) begin
                    if (changed < 32'(ndfd_pkg::CNT_MAX)) changed++;
                    if (changed > lim) differs = 1'b1;
                end
                blk_sum = 0;
            end
            if (it.plane_last) changed = 0;
            if (!it.frame_last) return;

            drop = have_ref && !differs;
            if (drop_lim > 0 && run_ctr >= drop_lim) drop = 1'b0;
            if (drop_lim < 0 && run_ctr - 1 > drop_lim) drop = 1'b0;
            if (drop) begin
                n = (run_ctr < 32767) ? run_ctr + 1 : 32767;
                run_ctr = (n < 1) ? 1 : n;
            end else begin
                n = (run_ctr > -32768) ? run_ctr - 1 : -32768;
                run_ctr = (n > -1) ? -1 : n;
                have_ref = 1'b1;
            end
            blk_sum = 0;
            changed = 0;
            differs = 1'b0;
            res.drop_frame = drop;
            res.run_count  = run_ctr[15:0];
            decisions_q.push_back(res);
            decided++;
        endfunction

        function int pending();
            return decisions_q.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_result(ndfd_pkg::out_item_t got);
            ndfd_pkg::out_item_t want;
            if (decisions_q.size() == 0) begin
                report($sformatf("unexpected decision drop=%0b run=%0d",
                                 got.drop_frame, got.run_count));
                return;
            end
            want = decisions_q.pop_front();
            if (got.drop_frame !== want.drop_frame)
                report($sformatf("drop_frame %0b, expected %0b",
                                 got.drop_frame, want.drop_frame));
            if (got.run_count !== want.run_count)
                report($sformatf("run_count %0d, expected %0d",
                                 got.run_count, want.run_count));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ndfd_pkg::in_item_t              s_item;
    logic                            m_valid;
    logic                            m_ready;
    ndfd_pkg::out_item_t             m_item;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ndfd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ndfd_pkg::CFG_DATA_W-1:0] cfg_data;

    decision_board sb = new();
    int            rows_sent = 0;
    bit            no_idle = 1'b0;
    bit            rx_hold_req = 1'b0;

    near_duplicate_frame_dropper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic ndfd_pkg::in_item_t make_row(input logic [63:0] cur,
                                                    input logic [63:0] prev,
                                                    input logic [1:0] plane, input logic blk,
                                                    input logic pl, input logic fr);
        ndfd_pkg::in_item_t it;
        it.cur_pixels     = cur;
        it.ref_pixels     = prev;
        it.plane_index    = plane;
        it.block_row_last = blk;
        it.plane_last     = pl;
        it.frame_last     = fr;
        return it;
    endfunction

    function automatic logic [63:0] nudge(input logic [63:0] base, input int maxd);
        logic [63:0] r;
        int          v;
        r = base;
        for (int i = 0; i < 8; i++) begin
            v = 32'(base[8*i +: 8]);
            if ($urandom_range(0, 1) != 0) v += int'($urandom_range(0, maxd));
            else v -= int'($urandom_range(0, maxd));
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r[8*i +: 8] = v[7:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] pad(input logic [16:0] v, input int w);
        logic [16:0] mask;
        mask = ~((17'd1 << w) - 17'd1);
        return ($urandom_range(0, 3) == 0) ? (v | (17'($urandom) & mask)) : v;
    endfunction

    task automatic send_row(input ndfd_pkg::in_item_t it);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_row(it);
        rows_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input ndfd_pkg::cfg_reg_t idx,
                             input logic [ndfd_pkg::CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic apply_setting(input logic [16:0] lo, input logic [16:0] hi,
                                 input logic [16:0] fr, input logic [16:0] dl,
                                 input logic [16:0] w, input logic [16:0] h,
                                 input logic [16:0] hs, input logic [16:0] vs);
        write_reg(ndfd_pkg::REG_LOW_THR, lo);
        write_reg(ndfd_pkg::REG_HIGH_THR, hi);
        write_reg(ndfd_pkg::REG_CHANGE_FR, fr);
        write_reg(ndfd_pkg::REG_DROP_LIMIT, dl);
        write_reg(ndfd_pkg::REG_WIDTH, w);
        write_reg(ndfd_pkg::REG_HEIGHT, h);
        write_reg(ndfd_pkg::REG_CHROMA_H, hs);
        write_reg(ndfd_pkg::REG_CHROMA_V, vs);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        logic [16:0] lo, hi, fr, dl, w, h;
        lo = 17'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                             : $urandom_range(100, 500));
        hi = 17'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                             : $urandom_range(300, 1500));
        case ($urandom_range(0, 3))
            0:       fr = 17'($urandom_range(0, 8192));
            1:       fr = 17'($urandom_range(0, 131071));
            default: fr = 17'($urandom_range(0, 65536));
        endcase
        dl = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'(16'($urandom_range(0, 8) - 4));
        case ($urandom_range(0, 9))
            0, 1:    w = 17'($urandom_range(0, 16383));
            2:       w = 17'($urandom_range(8, 8192));
            default: w = 17'($urandom_range(8, 80));
        endcase
        case ($urandom_range(0, 9))
            0, 1:    h = 17'($urandom_range(0, 16383));
            2:       h = 17'($urandom_range(8, 8192));
            default: h = 17'($urandom_range(8, 80));
        endcase
        apply_setting(pad(lo, 14), pad(hi, 14), fr, pad(dl, 16), pad(w, 14), pad(h, 14),
                      pad(17'($urandom_range(0, 3)), 2), pad(17'($urandom_range(0, 3)), 2));
    endtask

    task automatic run_directed();
        logic [63:0] ones, grey, lifted;
        ones   = '1;
        grey   = {8{8'h40}};
        lifted = {8{8'h46}};
        send_row(make_row('0, '0, 2'd0, 1'b0, 1'b0, 1'b1));
        send_row(make_row(ones, '0, 2'd3, 1'b1, 1'b1, 1'b1));
        send_row(make_row(ones, ones, 2'd2, 1'b1, 1'b1, 1'b1));
        // A block that runs past eight rows saturates its sum.
        repeat (9) send_row(make_row('0, ones, 2'd0, 1'b0, 1'b0, 1'b0));
        send_row(make_row(ones, '0, 2'd0, 1'b1, 1'b1, 1'b1));
        for (int i = 0; i < 8; i++)
            send_row(make_row(lifted, grey, 2'd1, i == 7, i == 7, i == 7));
        send_row(make_row('0, ones, 2'd1, 1'b1, 1'b0, 1'b0));
        send_row(make_row(grey, grey, 2'd0, 1'b0, 1'b1, 1'b1));
    endtask

    task automatic send_frame();
        int          kind, nplanes, nblocks, nrows, mode;
        logic [1:0]  plane;
        logic [63:0] base, cur;
        bit          pl_flag, last_row, last_blk, last_pl;
        ndfd_pkg::in_item_t junk;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 4)) begin
                junk = make_row({$urandom, $urandom}, {$urandom, $urandom},
                                2'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
                send_row(junk);
            end
            return;
        end
        kind    = int'($urandom_range(0, 99));
        nplanes = int'($urandom_range(1, 3));
        for (int p = 0; p < nplanes; p++) begin
            plane   = 2'($urandom_range(0, 3));
            nblocks = int'($urandom_range(1, 3));
            pl_flag = ($urandom_range(0, 9) != 0);
            last_pl = (p == nplanes - 1);
            for (int b = 0; b < nblocks; b++) begin
                if (kind < 40)      mode = int'($urandom_range(0, 1));
                else if (kind < 75) mode = int'($urandom_range(1, 2));
                else                mode = int'($urandom_range(0, 3));
                nrows    = ($urandom_range(0, 9) != 0) ? 8 : int'($urandom_range(1, 12));
                last_blk = (b == nblocks - 1);
                for (int r = 0; r < nrows; r++) begin
                    last_row = (r == nrows - 1);
                    base     = {$urandom, $urandom};
                    case (mode)
                        0:       cur = base;
                        1:       cur = nudge(base, 2);
                        2:       cur = nudge(base, 12);
                        default: cur = {$urandom, $urandom};
                    endcase
                    send_row(make_row(cur, base, plane, last_row,
                                      last_row && last_blk && pl_flag,
                                      last_row && last_blk && last_pl));
                end
            end
        end
    endtask

    task automatic send_repeats(input int count);
        logic [63:0] base;
        repeat (count) begin
            base = {$urandom, $urandom};
            send_row(make_row(base, base, 2'($urandom), 1'b1, 1'b1, 1'b1));
        end
    endtask

    initial begin
        int          stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_result(m_item);
            if (rx_hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int target;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ndfd_pkg::REG_LOW_THR;
        cfg_data  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            case (p)
                0:       apply_setting(17'd0, 17'd16383, 17'd0, 17'd1,
                                       17'd8, 17'd8, 17'd0, 17'd0);
                1:       apply_setting(17'd16320, 17'd16320, 17'd131071, 17'h0FFFF,
                                       17'd8192, 17'd8192, 17'd2, 17'd2);
                default: random_setting();
            endcase
            no_idle = (p == 2);
            target  = rows_sent + RANDOM_ROWS / RANDOM_PHASES;
            while (rows_sent < target) send_frame();
        end
        no_idle = 1'b0;

        // Runs of duplicate single-row frames build long runs of drops and keeps.
        drain();
        apply_setting(17'd320, 17'd768, 17'd21627, 17'd0, 17'd1920, 17'd1080, 17'd1, 17'd1);
        rx_hold_req = 1'b1;
        send_repeats(SAT_FRAMES);
        drain();
        apply_setting(17'd320, 17'd768, 17'd21627, 17'h08000,
                      17'd1920, 17'd1080, 17'd1, 17'd1);
        send_repeats(SAT_FRAMES);

        drain();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ndfd_pkg.sv
sv/ndfd_limit.sv
sv/ndfd_front.sv
sv/ndfd_queue.sv
sv/ndfd_back.sv
sv/near_duplicate_frame_dropper.sv
tb/sv/tb.sv
